// ===== rtl/assert_macros.svh =====
// Assertion macros for the blitter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on clk_i, disabled while rst_ni is low
`define CKB_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("blitter assertion failed");
// Property checked on a named clock and active-low reset
`define CKB_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("blitter assertion failed");
`else
`define CKB_ASSERT(label, prop)
`define CKB_ASSERT_CLK(label, clk, rst_n, prop)
`endif
`endif

// ===== rtl/ckb_pkg.sv =====
// Types and constants of the colour-keyed rectangle blitter
package ckb_pkg;

  localparam int MAX_DIM   = 2048;
  localparam int ADDR_BITS = 24;
  localparam int QDepth    = 2;

  typedef enum logic [2:0] {
    MODE_COPY     = 3'd0,
    MODE_KEY_SKIP = 3'd1,
    MODE_KEY_CLR  = 3'd2,
    MODE_KEY_REPL = 3'd3,
    MODE_KEY_SRC  = 3'd4,
    MODE_FILL     = 3'd5,
    MODE_HSPLIT   = 3'd6,
    MODE_VSPLIT   = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_KEY_COLOR   = 3'd1,
    REG_COLOR_A     = 3'd2,
    REG_COLOR_B     = 3'd3,
    REG_RECT_WIDTH  = 3'd4,
    REG_RECT_HEIGHT = 3'd5,
    REG_DST_STRIDE  = 3'd6,
    REG_SPLIT_POS   = 3'd7
  } reg_idx_e;

  // Pixel source chosen by the front end
  typedef enum logic [2:0] {
    OP_SRC     = 3'd0,
    OP_BG      = 3'd1,
    OP_COLOR_A = 3'd2,
    OP_COLOR_B = 3'd3,
    OP_SKIP    = 3'd4
  } op_e;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] key_color;
    logic [31:0] color_a;
    logic [31:0] color_b;
    logic [11:0] rect_width;
    logic [11:0] rect_height;
    logic [13:0] dst_stride;
    logic [11:0] split_pos;
  } cfg_t;

  typedef struct packed {
    logic [31:0] src_pixel;
    logic [31:0] bg_pixel;
  } in_item_t;

  typedef struct packed {
    logic [23:0] dst_offset;
    logic [31:0] pixel_out;
    logic        write_en;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [23:0] dst_offset;
    logic        last;
    logic [31:0] src_pixel;
    logic [31:0] bg_pixel;
  } q_entry_t;

endpackage

// ===== rtl/ckb_front.sv =====
// Front end: raster position tracking, offset generation and pixel classification
module ckb_front import ckb_pkg::*; #(
  parameter int MaxDim   = MAX_DIM,
  parameter int AddrBits = ADDR_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     full_i,
  output logic     push_o,
  output q_entry_t entry_o
);

  localparam int CntW = $clog2(MaxDim);
  localparam int DimW = $clog2(MaxDim + 1);

  logic [CntW-1:0]     col_q, col_d, row_q, row_d, col_e, row_e;
  logic [AddrBits-1:0] base_q, base_d, base_e, offset;
  logic [DimW-1:0]     w, h;
  logic                empty, outside, last_col, last_row, is_last, key, accept;
  op_e                 op;

  // Clamp the rectangle to the supported size
  assign w = (32'(cfg_i.rect_width) > 32'(MaxDim)) ? DimW'(MaxDim) : DimW'(cfg_i.rect_width);
  assign h = (32'(cfg_i.rect_height) > 32'(MaxDim)) ? DimW'(MaxDim)
                                                     : DimW'(cfg_i.rect_height);

  assign empty   = (w == '0) || (h == '0);
  assign outside = (DimW'(col_q) >= w) || (DimW'(row_q) >= h);

  // Restart at the origin when the rectangle shrank under the current position
  assign col_e  = outside ? '0 : col_q;
  assign row_e  = outside ? '0 : row_q;
  assign base_e = outside ? '0 : base_q;

  assign offset   = AddrBits'(32'(base_e) + 32'(col_e));
  assign last_col = DimW'(col_e) == (w - DimW'(1));
  assign last_row = DimW'(row_e) == (h - DimW'(1));
  assign is_last  = last_col && last_row;
  assign key      = in_data_i.src_pixel == cfg_i.key_color;

  always_comb begin
    unique case (cfg_i.mode)
      MODE_COPY:     op = OP_SRC;
      MODE_KEY_SKIP: op = key ? OP_SKIP : OP_SRC;
      MODE_KEY_CLR:  op = key ? OP_COLOR_A : OP_SRC;
      MODE_KEY_REPL: op = key ? OP_BG : OP_COLOR_A;
      MODE_KEY_SRC:  op = key ? OP_BG : OP_SRC;
      MODE_FILL:     op = OP_COLOR_A;
      MODE_HSPLIT:   op = (32'(col_e) < 32'(cfg_i.split_pos)) ? OP_COLOR_A : OP_COLOR_B;
      MODE_VSPLIT:   op = (32'(row_e) < 32'(cfg_i.split_pos)) ? OP_COLOR_A : OP_COLOR_B;
      default:       op = OP_SKIP;
    endcase
  end

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  always_comb begin
    entry_o.src_pixel = in_data_i.src_pixel;
    entry_o.bg_pixel  = in_data_i.bg_pixel;
    if (empty) begin
      entry_o.op         = OP_SKIP;
      entry_o.dst_offset = '0;
      entry_o.last       = 1'b1;
    end else begin
      entry_o.op         = op;
      entry_o.dst_offset = 24'(offset);
      entry_o.last       = is_last;
    end
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    base_d = base_q;
    if (accept && !empty) begin
      priority if (is_last) begin
        col_d  = '0;
        row_d  = '0;
        base_d = '0;
      end else if (last_col) begin
        col_d  = '0;
        row_d  = row_e + CntW'(1);
        base_d = AddrBits'(32'(base_e) + 32'(cfg_i.dst_stride));
      end else begin
        col_d  = col_e + CntW'(1);
        row_d  = row_e;
        base_d = base_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      base_q <= base_d;
    end
  end

endmodule

// ===== rtl/ckb_fifo.sv =====
// Two-entry queue between the front end and the output stage
`include "assert_macros.svh"
module ckb_fifo import ckb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t entry_o
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  q_entry_t        mem_q [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(QDepth);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  `CKB_ASSERT_CLK(a_no_overflow, clk_i, rst_ni, push_i |-> !full_o)
  `CKB_ASSERT_CLK(a_no_underflow, clk_i, rst_ni, pop_i |-> valid_o)
  `CKB_ASSERT_CLK(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(QDepth))
  `CKB_ASSERT(a_cnt_step, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CntW'(1)))

endmodule

// ===== rtl/ckb_back.sv =====
// Back end: pixel selection and registered result output
module ckb_back import ckb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      valid_i,
  input  q_entry_t  entry_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, res;

  always_comb begin
    res.dst_offset = entry_i.dst_offset;
    res.last       = entry_i.last;
    res.write_en   = 1'b1;
    unique case (entry_i.op)
      OP_SRC:     res.pixel_out = entry_i.src_pixel;
      OP_BG:      res.pixel_out = entry_i.bg_pixel;
      OP_COLOR_A: res.pixel_out = cfg_i.color_a;
      OP_COLOR_B: res.pixel_out = cfg_i.color_b;
      default: begin
        res.pixel_out = '0;
        res.write_en  = 1'b0;
      end
    endcase
  end

  // Refill the output register when it is empty or being drained
  assign pop_o = valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/color_keyed_rect_blit_fill.sv =====
// Top level of the colour-keyed rectangle blitter
// Accepts one source/background pixel pair per clock, in row-major order over the
// programmed rectangle, and returns one result per pair: destination offset, pixel,
// write enable and end-of-rectangle flag. Sustained rate is one transaction per clock
// on each side while the output is not stalled. A pair is written into the queue when
// it is accepted and then moves into the output register, which presents the result.
// A two-entry queue and an output register let the input keep flowing while a result
// waits. Configuration writes are always ready and must only be issued while no
// transaction is in flight.
module color_keyed_rect_blit_fill import ckb_pkg::*; #(
  parameter int MaxDim   = MAX_DIM,
  parameter int AddrBits = ADDR_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  cfg_t     cfg_q;
  q_entry_t push_entry, pop_entry;
  logic     push, pop, full, q_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MODE:        cfg_q.mode        <= mode_e'(cfg_data_i[2:0]);
        REG_KEY_COLOR:   cfg_q.key_color   <= cfg_data_i;
        REG_COLOR_A:     cfg_q.color_a     <= cfg_data_i;
        REG_COLOR_B:     cfg_q.color_b     <= cfg_data_i;
        REG_RECT_WIDTH:  cfg_q.rect_width  <= cfg_data_i[11:0];
        REG_RECT_HEIGHT: cfg_q.rect_height <= cfg_data_i[11:0];
        REG_DST_STRIDE:  cfg_q.dst_stride  <= cfg_data_i[13:0];
        REG_SPLIT_POS:   cfg_q.split_pos   <= cfg_data_i[11:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  ckb_front #(
    .MaxDim  (MaxDim),
    .AddrBits(AddrBits)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  ckb_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .entry_o(pop_entry)
  );

  ckb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (q_valid),
    .entry_i    (pop_entry),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== sim/blit_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the blitter: predicts each destination write and compares results
module blit_checker import ckb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          key_hits_o,
  output int          lasts_o,
  output int          skips_o
);

  // Shadow copy of the register file
  mode_e       cur_mode;
  logic [31:0] key_color;
  logic [31:0] color_a;
  logic [31:0] color_b;
  logic [11:0] rect_w;
  logic [11:0] rect_h;
  logic [13:0] stride;
  logic [11:0] split;

  // Raster position
  int          col;
  int          row;
  logic [23:0] row_base;

  out_item_t   pending_writes[$];

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", results_o, what, got, want);
    fail_count_o++;
  endtask

  function automatic out_item_t compute_dst_write(input in_item_t px);
    out_item_t res;
    int        w;
    int        h;
    logic      keyed;
    w = (int'(rect_w) > MAX_DIM) ? MAX_DIM : int'(rect_w);
    h = (int'(rect_h) > MAX_DIM) ? MAX_DIM : int'(rect_h);
    res = '0;
    // Empty rectangle: no write, end flag only, position untouched
    if (w == 0 || h == 0) begin
      res.last = 1'b1;
      return res;
    end
    // Size shrank under the current position: restart at the origin
    if (col >= w || row >= h) begin
      col = 0;
      row = 0;
      row_base = '0;
    end
    keyed = (px.src_pixel == key_color);
    res.dst_offset = row_base + 24'(col);
    res.write_en = 1'b1;
    case (cur_mode)
      MODE_COPY:     res.pixel_out = px.src_pixel;
      MODE_KEY_SKIP: begin
        res.pixel_out = px.src_pixel;
        res.write_en = !keyed;
      end
      MODE_KEY_CLR:  res.pixel_out = keyed ? color_a : px.src_pixel;
      MODE_KEY_REPL: res.pixel_out = keyed ? px.bg_pixel : color_a;
      MODE_KEY_SRC:  res.pixel_out = keyed ? px.bg_pixel : px.src_pixel;
      MODE_FILL:     res.pixel_out = color_a;
      MODE_HSPLIT:   res.pixel_out = (col < int'(split)) ? color_a : color_b;
      default:       res.pixel_out = (row < int'(split)) ? color_a : color_b;
    endcase
    if (!res.write_en) res.pixel_out = '0;
    res.last = (col == w - 1) && (row == h - 1);
    if (res.last) begin
      col = 0;
      row = 0;
      row_base = '0;
    end else if (col == w - 1) begin
      col = 0;
      row++;
      row_base = row_base + 24'(stride);
    end else begin
      col++;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode = MODE_COPY;
      key_color = '0;
      color_a = '0;
      color_b = '0;
      rect_w = '0;
      rect_h = '0;
      stride = '0;
      split = '0;
      col = 0;
      row = 0;
      row_base = '0;
      pending_writes.delete();
      fail_count_o = 0;
      pending_o = 0;
      results_o = 0;
      key_hits_o = 0;
      lasts_o = 0;
      skips_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_MODE:        cur_mode = mode_e'(cfg_data_i[2:0]);
          REG_KEY_COLOR:   key_color = cfg_data_i;
          REG_COLOR_A:     color_a = cfg_data_i;
          REG_COLOR_B:     color_b = cfg_data_i;
          REG_RECT_WIDTH:  rect_w = cfg_data_i[11:0];
          REG_RECT_HEIGHT: rect_h = cfg_data_i[11:0];
          REG_DST_STRIDE:  stride = cfg_data_i[13:0];
          REG_SPLIT_POS:   split = cfg_data_i[11:0];
        endcase
      end
      // Compare before queueing so a result leaving in the same cycle as its input cannot match itself
      if (out_valid_i && out_ready_i) begin
        if (pending_writes.size() == 0) begin
          flag_mismatch("unexpected result, offset", 32'(out_data_i.dst_offset), '0);
        end else begin
          out_item_t want;
          want = pending_writes.pop_front();
          if (out_data_i.dst_offset !== want.dst_offset)
            flag_mismatch("dst_offset", 32'(out_data_i.dst_offset), 32'(want.dst_offset));
          if (out_data_i.pixel_out !== want.pixel_out)
            flag_mismatch("pixel_out", out_data_i.pixel_out, want.pixel_out);
          if (out_data_i.write_en !== want.write_en)
            flag_mismatch("write_en", 32'(out_data_i.write_en), 32'(want.write_en));
          if (out_data_i.last !== want.last)
            flag_mismatch("last", 32'(out_data_i.last), 32'(want.last));
          if (want.last) lasts_o++;
          if (!want.write_en) skips_o++;
        end
        results_o++;
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.src_pixel == key_color) key_hits_o++;
        pending_writes.push_back(compute_dst_write(in_data_i));
      end
      pending_o = pending_writes.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench top: drives pixels and register writes into the blitter and gives the verdict
module tb;
  import ckb_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 8;
  localparam int SmallItems  = 750;
  localparam int TallItems   = 1050;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;

  int fail_count;
  int pending;
  int results;
  int key_hits;
  int lasts;
  int skips;
  int idle_cycles = 0;
  int setups = 0;
  bit sender_quiet = 1'b0;
  bit receiver_quiet = 1'b0;

  color_keyed_rect_blit_fill dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  blit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .key_hits_o   (key_hits),
    .lasts_o      (lasts),
    .skips_o      (skips)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // End the run when no transaction of any kind has happened for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 IdleLimit, pending);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: stall a random number of cycles before each transaction
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = receiver_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready = 1'b1;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_pixel(input logic [31:0] src, input logic [31:0] bg);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data = '{src_pixel: src, bg_pixel: bg};
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // Hold the input until every outstanding result is back
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  // Unused upper data bits carry noise; the block keeps only the register width
  task automatic load_setup(input mode_e m, input logic [31:0] key, input logic [31:0] a,
                            input logic [31:0] b, input logic [11:0] w,
                            input logic [11:0] h, input logic [13:0] stride,
                            input logic [11:0] split);
    drain();
    write_reg(REG_MODE, {29'($urandom()), m});
    write_reg(REG_KEY_COLOR, key);
    write_reg(REG_COLOR_A, a);
    write_reg(REG_COLOR_B, b);
    write_reg(REG_RECT_WIDTH, {20'($urandom()), w});
    write_reg(REG_RECT_HEIGHT, {20'($urandom()), h});
    write_reg(REG_DST_STRIDE, {18'($urandom()), stride});
    write_reg(REG_SPLIT_POS, {20'($urandom()), split});
    cfg_valid = 1'b0;
    setups++;
  endtask

  // Mostly tiny rectangles, now and then empty, mid-sized or oversize
  function automatic logic [11:0] draw_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 12'd0;
    if (r == 1) return 12'($urandom_range(2048, 4095));
    if (r == 2) return 12'($urandom_range(9, 2048));
    return 12'($urandom_range(1, 8));
  endfunction

  initial begin : stimulus
    int          small_sent;
    int          items;
    int          hold_at;
    int          phase;
    logic [11:0] w;
    logic [11:0] h;
    logic [31:0] key;
    logic [31:0] src;

    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Registers still at reset: empty rectangle
    send_pixel(32'h0, 32'h0);

    load_setup(MODE_COPY, 32'h0, 32'h0, 32'h0, 12'd2, 12'd2, 14'h3FFF, 12'd0);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(32'h0000_0000, 32'h0000_0000);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);

    load_setup(MODE_KEY_SKIP, 32'hFFFF_FFFF, 32'h0, 32'h0, 12'd2, 12'd1, 14'd0, 12'd0);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF);

    load_setup(MODE_KEY_CLR, 32'h0, 32'hAAAA_AAAA, 32'h0, 12'd2, 12'd1, 14'd5, 12'd0);
    send_pixel(32'h0000_0000, 32'h1111_1111);
    send_pixel(32'h1234_5678, 32'h2222_2222);

    load_setup(MODE_KEY_REPL, 32'h5A5A_5A5A, 32'h5555_5555, 32'h0, 12'd2, 12'd1, 14'd5,
               12'd0);
    send_pixel(32'h5A5A_5A5A, 32'hFFFF_FFFF);
    send_pixel(32'h0000_0000, 32'h0000_0000);

    load_setup(MODE_KEY_SRC, 32'h5A5A_5A5A, 32'h5555_5555, 32'h0, 12'd2, 12'd1, 14'd5,
               12'd0);
    send_pixel(32'h5A5A_5A5A, 32'hC3C3_C3C3);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);

    load_setup(MODE_FILL, 32'h0, 32'hDEAD_BEEF, 32'h0, 12'd1, 12'd1, 14'd0, 12'd0);
    send_pixel($urandom(), $urandom());

    load_setup(MODE_HSPLIT, 32'h0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 12'd3, 12'd1, 14'd0,
               12'd1);
    repeat (3) send_pixel($urandom(), $urandom());

    // Split row past the bottom edge: whole rectangle takes the first colour
    load_setup(MODE_VSPLIT, 32'h0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 12'd1, 12'd3, 14'd7,
               12'hFFF);
    repeat (3) send_pixel($urandom(), $urandom());

    // Oversize dimensions saturate; then shrink under the current position
    load_setup(MODE_COPY, 32'h0, 32'h0, 32'h0, 12'hFFF, 12'hFFF, 14'd1, 12'd0);
    repeat (2) send_pixel($urandom(), $urandom());
    load_setup(MODE_COPY, 32'h0, 32'h0, 32'h0, 12'd1, 12'd1, 14'd1, 12'd0);
    send_pixel($urandom(), $urandom());

    // Zero width with a non-zero height is still empty
    load_setup(MODE_FILL, 32'h0, 32'hFFFF_FFFF, 32'h0, 12'd0, 12'd5, 14'd3, 12'd0);
    send_pixel($urandom(), $urandom());

    small_sent = 0;
    phase = 0;
    while (small_sent < SmallItems) begin
      w = draw_dim();
      h = draw_dim();
      key = $urandom();
      load_setup(mode_e'($urandom_range(0, 7)), key, $urandom(), $urandom(), w, h,
                 ($urandom_range(0, 1) == 1) ? 14'($urandom()) : 14'($urandom_range(0, 16)),
                 ($urandom_range(0, 3) == 0) ? 12'($urandom())
                                             : 12'($urandom_range(0, int'(w) + 1)));
      sender_quiet = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      items = $urandom_range(20, 120);
      hold_at = (phase == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(1, items - 1) : -1;
      for (int i = 0; i < items; i++) begin
        if (i == hold_at) drain();
        src = ($urandom_range(0, 2) == 0) ? key : $urandom();
        send_pixel(src, $urandom());
      end
      small_sent += items;
      phase++;
    end

    // Tall one-pixel stripe with a near-maximum stride: offsets wrap past 24 bits
    key = $urandom();
    load_setup(mode_e'($urandom_range(0, 7)), key, $urandom(), $urandom(), 12'd1,
               12'($urandom_range(2048, 4095)), 14'($urandom_range(16368, 16383)),
               12'($urandom_range(0, 2047)));
    for (int i = 0; i < TallItems; i++) begin
      sender_quiet = ((i / 150) % 2 == 0);
      receiver_quiet = ((i / 200) % 2 == 1);
      src = ($urandom_range(0, 2) == 0) ? key : $urandom();
      send_pixel(src, $urandom());
    end

    drain();
    $display("covered %0d results over %0d register setups, all modes, empty and oversize",
             results, setups);
    $display("%0d rectangle ends, %0d key matches, %0d suppressed writes, address wrap",
             lasts, key_hits, skips);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ckb_pkg.sv
rtl/ckb_front.sv
rtl/ckb_fifo.sv
rtl/ckb_back.sv
rtl/color_keyed_rect_blit_fill.sv
sim/blit_checker.sv
sim/tb.sv
